// ===== rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the slot memory and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   // Request codes carried on req_type.
   localparam logic [2:0] REQ_CREATE   = 3'd0;
   localparam logic [2:0] REQ_TICK     = 3'd1;
   localparam logic [2:0] REQ_DISPATCH = 3'd2;
   localparam logic [2:0] REQ_YIELD    = 3'd3;
   localparam logic [2:0] REQ_EXIT     = 3'd4;
   localparam logic [2:0] REQ_GUARD    = 3'd5;

   // Status codes returned on rsp_status.
   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_IGNORED = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_FAULT   = 2'd3;

   // Time slice length after reset.
   localparam logic [7:0] DEFAULT_TIMESLICE = 8'd5;

   // Life cycle of one task slot.
   typedef enum logic [1:0] {
      RS_UNUSED,
      RS_READY,
      RS_RUNNING,
      RS_EXITED
   } run_state_type;

   // One word of the slot table.
   typedef struct packed {
      run_state_type st;
      logic [7:0]    slice;
      logic          guard;
   } slot_entry_type;

   // Contents of the idle slot after reset.
   localparam slot_entry_type SLOT_RESET = '{st: RS_READY, slice: 8'd0, guard: 1'b0};

endpackage

`default_nettype wire

// ===== rtl/rrts_slot_mem.sv =====
// Slot table memory: one write port, one read port, registered read data.
// Depends on rrts_pkg for the entry type and the reset contents of slot 0.
`timescale 1ns / 1ps
`default_nettype none

module rrts_slot_mem
   import rrts_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire slot_entry_type wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   output slot_entry_type      rd_data
);

   slot_entry_type mem [DEPTH];
   slot_entry_type raw_ff;
   logic           zero_valid_ff;
   logic           zero_valid_in;
   logic           rd_zero_ff;

   // Only the idle slot is read before it is written, so it alone carries a valid bit.
   assign zero_valid_in = zero_valid_ff | (wr_en & (wr_addr == '0));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff     <= mem[rd_addr];
      rd_zero_ff <= (rd_addr == '0) & ~zero_valid_ff;
      if (reset) begin
         zero_valid_ff <= 1'b0;
      end else begin
         zero_valid_ff <= zero_valid_in;
      end
   end

   // An unwritten idle slot reads as its reset contents.
   assign rd_data = rd_zero_ff ? SLOT_RESET : raw_ff;

endmodule

`default_nettype wire

// ===== rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler: sequencer, counters and status around the slot table.
// Depends on rrts_pkg and rrts_slot_mem.
//
//   channel   ports                         direction  handshake
//   request   req_type, req_task_slot       in         start high and busy low
//   result    rsp_*                         out        rsp_valid for one cycle
//   config    csr_wr_en, csr_wr_data        in         write when csr_wr_en high
//
// Create, tick, yield, exit, guard reports and ignored dispatches pass through ST_EXEC, which
// sets rsp_valid through a register. A dispatch that starts a scan passes through ST_SCAN,
// scanning at most task_total slots, one slot table entry per cycle through the read port.
// Reset is synchronous, active high; the slot table itself is not cleared.
// The receiver cannot stall; busy is low again in the cycle rsp_valid is high.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [3:0]  req_task_slot,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_chosen_slot,
   output logic [3:0]       rsp_current_slot,
   output logic             rsp_in_task,
   output logic             rsp_should_yield,
   output logic [4:0]       rsp_runnable_count,
   output logic [4:0]       rsp_task_total,
   output logic [31:0]      rsp_tick_total,
   output logic [31:0]      rsp_dispatch_total,
   output logic [31:0]      rsp_yield_total,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int CMP_W  = CNT_W + 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [3:0]         slot_ff, slot_in;
   logic [SLOT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   ready_ff, ready_in;
   logic [SLOT_W-1:0]  running_ff, running_in;
   logic [SLOT_W-1:0]  last_ff, last_in;
   logic               pending_ff, pending_in;
   logic               in_task_ff, in_task_in;
   logic [31:0]        tick_ff, tick_in;
   logic [31:0]        disp_ff, disp_in;
   logic [31:0]        yield_ff, yield_in;
   logic [7:0]         timeslice_ff, timeslice_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [SLOT_W-1:0]  chosen_ff, chosen_in;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   slot_entry_type     wr_data;
   slot_entry_type     rd_data;
   logic [7:0]         slice_nx;
   logic               leave;
   run_state_type      leave_st;
   logic [SLOT_W+3:0]  req_slot_wide;
   logic [SLOT_W+3:0]  chosen_wide;
   logic [SLOT_W+3:0]  running_wide;
   logic [CNT_W+4:0]   ready_wide;
   logic [CNT_W+4:0]   used_wide;

   // Next slot in round-robin order, wrapping at the number of used slots.
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] cur,
                                                   input logic [CNT_W-1:0]  used);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(cur) + CNT_W'(1);
      if (nxt >= used) begin
         return '0;
      end
      return nxt[SLOT_W-1:0];
   endfunction

   rrts_slot_mem #(
      .DEPTH (MAX_TASKS),
      .AW    (SLOT_W)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   assign req_slot_wide = {{SLOT_W{1'b0}}, req_task_slot};
   assign timeslice_in  = csr_wr_en ? csr_wr_data : timeslice_ff;

   // Sequencer: issue the read on accept, then modify and write back the entry.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      ready_in     = ready_ff;
      running_in   = running_ff;
      last_in      = last_ff;
      pending_in   = pending_ff;
      in_task_in   = in_task_ff;
      tick_in      = tick_ff;
      disp_in      = disp_ff;
      yield_in     = yield_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      chosen_in    = chosen_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = rd_data;
      slice_nx     = rd_data.slice + 8'd1;
      leave        = 1'b0;
      leave_st     = RS_EXITED;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_type;
               slot_in  = req_task_slot;
               state_in = ST_EXEC;
               addr_in  = running_ff;
               if (req_type == REQ_GUARD) begin
                  addr_in = req_slot_wide[SLOT_W-1:0];
               end
               if ((req_type == REQ_DISPATCH) && !in_task_ff && pending_ff) begin
                  addr_in  = next_slot(last_ff, used_ff);
                  cnt_in   = CNT_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            chosen_in    = running_ff;
            status_in    = STS_IGNORED;
            unique case (op_ff)
               REQ_CREATE: begin
                  if (used_ff < CNT_W'(MAX_TASKS)) begin
                     wr_en      = 1'b1;
                     wr_addr    = used_ff[SLOT_W-1:0];
                     wr_data    = '{st: RS_READY, slice: 8'd0, guard: 1'b0};
                     used_in    = used_ff + CNT_W'(1);
                     ready_in   = ready_ff + CNT_W'(1);
                     pending_in = 1'b1;
                     status_in  = STS_DONE;
                     chosen_in  = used_ff[SLOT_W-1:0];
                  end else begin
                     status_in = STS_FULL;
                  end
               end
               REQ_TICK: begin
                  tick_in = tick_ff + 32'd1;
                  if ((timeslice_ff != 8'd0) && (slice_nx >= timeslice_ff)) begin
                     slice_nx   = 8'd0;
                     pending_in = 1'b1;
                  end
                  wr_en         = 1'b1;
                  wr_addr       = running_ff;
                  wr_data.slice = slice_nx;
                  status_in     = STS_DONE;
               end
               REQ_YIELD: begin
                  if (in_task_ff && (running_ff != '0)) begin
                     leave = 1'b1;
                     if (rd_data.guard) begin
                        leave_st  = RS_EXITED;
                        ready_in  = ready_ff - CNT_W'(1);
                        status_in = STS_FAULT;
                     end else begin
                        leave_st  = RS_READY;
                        yield_in  = yield_ff + 32'd1;
                        status_in = STS_DONE;
                     end
                  end
               end
               REQ_EXIT: begin
                  if (running_ff != '0) begin
                     leave     = 1'b1;
                     leave_st  = RS_EXITED;
                     ready_in  = ready_ff - CNT_W'(1);
                     status_in = STS_DONE;
                  end
               end
               REQ_GUARD: begin
                  if ((slot_ff != 4'd0) && (CMP_W'(slot_ff) < CMP_W'(used_ff))) begin
                     wr_en         = 1'b1;
                     wr_addr       = addr_ff;
                     wr_data.guard = 1'b1;
                     status_in     = STS_DONE;
                  end
               end
               default: begin
                  status_in = STS_IGNORED;
               end
            endcase

            // The running task hands control back to the scheduler.
            if (leave) begin
               wr_en         = 1'b1;
               wr_addr       = running_ff;
               wr_data.st    = leave_st;
               wr_data.slice = 8'd0;
               pending_in    = 1'b1;
               in_task_in    = 1'b0;
               running_in    = '0;
            end
         end

         ST_SCAN: begin
            // Read data belongs to addr_ff, issued in the previous cycle.
            if ((rd_data.st == RS_READY) && (addr_ff != '0)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               chosen_in    = addr_ff;
               wr_en        = 1'b1;
               wr_addr      = addr_ff;
               if (rd_data.guard) begin
                  wr_data.st = RS_EXITED;
                  pending_in = 1'b1;
                  ready_in   = ready_ff - CNT_W'(1);
                  status_in  = STS_FAULT;
               end else begin
                  wr_data.st    = RS_RUNNING;
                  wr_data.slice = 8'd0;
                  last_in       = addr_ff;
                  running_in    = addr_ff;
                  disp_in       = disp_ff + 32'd1;
                  pending_in    = 1'b0;
                  in_task_in    = 1'b1;
                  status_in     = STS_DONE;
               end
            end else if (cnt_ff < used_ff) begin
               addr_in = next_slot(addr_ff, used_ff);
               cnt_in  = cnt_ff + CNT_W'(1);
            end else begin
               // No ready task: the idle slot runs.
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               running_in   = '0;
               pending_in   = 1'b0;
               status_in    = STS_DONE;
               chosen_in    = '0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      slot_ff   <= slot_in;
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      chosen_ff <= chosen_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= CNT_W'(1);
         ready_ff     <= CNT_W'(1);
         running_ff   <= '0;
         last_ff      <= '0;
         pending_ff   <= 1'b1;
         in_task_ff   <= 1'b0;
         tick_ff      <= '0;
         disp_ff      <= '0;
         yield_ff     <= '0;
         timeslice_ff <= DEFAULT_TIMESLICE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ready_ff     <= ready_in;
         running_ff   <= running_in;
         last_ff      <= last_in;
         pending_ff   <= pending_in;
         in_task_ff   <= in_task_in;
         tick_ff      <= tick_in;
         disp_ff      <= disp_in;
         yield_ff     <= yield_in;
         timeslice_ff <= timeslice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result ports, fitted to the fixed port widths.
   assign chosen_wide  = {4'd0, chosen_ff};
   assign running_wide = {4'd0, running_ff};
   assign ready_wide   = {5'd0, ready_ff};
   assign used_wide    = {5'd0, used_ff};

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_chosen_slot    = chosen_wide[3:0];
   assign rsp_current_slot   = running_wide[3:0];
   assign rsp_in_task        = in_task_ff;
   assign rsp_should_yield   = in_task_ff & pending_ff;
   assign rsp_runnable_count = ready_wide[4:0];
   assign rsp_task_total     = used_wide[4:0];
   assign rsp_tick_total     = tick_ff;
   assign rsp_dispatch_total = disp_ff;
   assign rsp_yield_total    = yield_ff;

   // A result only follows a cycle of work on an item.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != ST_IDLE))
      else $error("result strobe without an item in progress");

   // A non-idle task runs exactly when the in-task flag is set.
   a_in_task_match: assert property (@(posedge clock) disable iff (reset)
      in_task_ff == (running_ff != '0))
      else $error("in-task flag disagrees with running slot");

   // Ready count covers the idle slot and never exceeds the used slots.
   a_ready_bounds: assert property (@(posedge clock) disable iff (reset)
      (ready_ff >= CNT_W'(1)) && (ready_ff <= used_ff))
      else $error("ready count out of range");

   // Used slots stay within the table.
   a_used_bounds: assert property (@(posedge clock) disable iff (reset)
      (used_ff >= CNT_W'(1)) && (used_ff <= CNT_W'(MAX_TASKS)))
      else $error("used slot count out of range");

   // The scan never reads more entries than there are used slots.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((cnt_ff <= used_ff) && (CNT_W'(addr_ff) < used_ff)))
      else $error("scan ran past the used slots");

endmodule

`default_nettype wire
